// ----- design/raised_cosine_fade_gain_core_defines.svh -----
// Assertion macros shared by the fade gain core.
// Needs a clock named clk and an active-high synchronous reset named rst in scope.
`ifndef RAISED_COSINE_FADE_GAIN_CORE_DEFINES_SVH
`define RAISED_COSINE_FADE_GAIN_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCFG_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rcfg_pkg.sv -----
// Shared types, constants and tables of the raised cosine fade gain core.
// No dependencies; rcfg_div, rcfg_ctrl, rcfg_dp and the top level refer to it by scoped names.
package rcfg_pkg;

  // Default sizes of the sample frame.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CHANNELS_DEF    = 2;

  // Register and state widths.
  localparam int POS_BITS       = 21;
  localparam int LEN_BITS       = 20;
  localparam int LEVEL_BITS     = 20;
  localparam int CFG_INDEX_BITS = 1;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_GAIN  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_LENGTH = 1'd1;

  localparam logic [LEVEL_BITS-1:0] LEVEL_GAIN_RESET = 20'd65536;

  // Phase divider: quotient bits and iteration counter width.
  localparam int Q_BITS       = 31;
  localparam int DIV_CNT_BITS = 5;

  // Fixed-point constants of the sine evaluation.
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [16:0] FADE_UNITY  = 17'd65536;

  // Combined gain is Q24, at most 29 bits wide.
  localparam int GAIN_BITS  = 29;
  localparam int GAIN_FRAC  = 24;

  // Divisors of the nested sine series and their reciprocals in Q32.
  localparam int SERIES_TERMS = 4;
  localparam logic [6:0]  SERIES_DIV_0 = 7'd72;
  localparam logic [6:0]  SERIES_DIV_1 = 7'd42;
  localparam logic [6:0]  SERIES_DIV_2 = 7'd20;
  localparam logic [6:0]  SERIES_DIV_3 = 7'd6;
  localparam logic [31:0] RECIP_0 = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RECIP_1 = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RECIP_2 = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RECIP_3 = 32'((64'd1 << 32) / 64'd6);

  function automatic logic [6:0] series_div(input logic [1:0] k);
    logic [6:0] d;
    case (k)
      2'd0:    d = SERIES_DIV_0;
      2'd1:    d = SERIES_DIV_1;
      2'd2:    d = SERIES_DIV_2;
      default: d = SERIES_DIV_3;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] series_recip(input logic [1:0] k);
    logic [31:0] m;
    case (k)
      2'd0:    m = RECIP_0;
      2'd1:    m = RECIP_1;
      2'd2:    m = RECIP_2;
      default: m = RECIP_3;
    endcase
    return m;
  endfunction

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_FOLD, S_DIV, S_X, S_X2, S_RECIP, S_CORR, S_TY,
    S_SINE, S_SQ, S_GAIN, S_CMUL, S_CSAT, S_FINISH
  } state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_FOLD, OP_X, OP_X2, OP_RECIP, OP_CORR, OP_TY,
    OP_SINE, OP_SQ, OP_GAIN, OP_CMUL, OP_CSAT, OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic half_zero;
    logic div_last;
    logic k_last;
    logic ch_last;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic                      en;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [LEVEL_BITS-1:0]     data;
  } cfg_wr_t;

endpackage

// ----- design/rcfg_div.sv -----
// Radix-2 restoring divider that forms the Q30 window phase.
// Depends on rcfg_pkg for its widths.
module rcfg_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rcfg_pkg::LEN_BITS-1:0]     divisor,
  input  logic [rcfg_pkg::LEN_BITS-1:0]     rem_init,
  input  logic [rcfg_pkg::Q_BITS-1:0]       bits_init,
  output logic                              last,
  output logic [rcfg_pkg::Q_BITS-1:0]       quotient
);

  logic                              run;
  logic [rcfg_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [rcfg_pkg::LEN_BITS-1:0]     rem;
  logic [rcfg_pkg::LEN_BITS-1:0]     dvs;
  logic [rcfg_pkg::Q_BITS-1:0]       bits;
  logic [rcfg_pkg::LEN_BITS:0]       rs;
  logic [rcfg_pkg::LEN_BITS:0]       diff;
  logic                              fits;

  // One quotient bit per cycle: shift in the next dividend bit and trial subtract.
  assign rs   = {rem, bits[rcfg_pkg::Q_BITS-1]};
  assign fits = rs >= {1'b0, dvs};
  assign diff = rs - {1'b0, dvs};
  assign last = run && (cnt == rcfg_pkg::DIV_CNT_BITS'(rcfg_pkg::Q_BITS - 1));
  assign quotient = bits;

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        run <= 1'b0;
      end
    end
  end

  // Partial remainder, divisor and the dividend bits that turn into quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      bits <= bits_init;
      dvs  <= divisor;
    end else if (run) begin
      rem  <= fits ? diff[rcfg_pkg::LEN_BITS-1:0] : rs[rcfg_pkg::LEN_BITS-1:0];
      bits <= {bits[rcfg_pkg::Q_BITS-2:0], fits};
    end
  end

endmodule

// ----- design/rcfg_ctrl.sv -----
// Sequencing state machine of the fade gain core.
// Depends on rcfg_pkg for its state, command and status types.
module rcfg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rcfg_pkg::status_t   status,
  output logic                in_ready,
  output rcfg_pkg::cmd_t      cmd
);

  rcfg_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcfg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rcfg_pkg::S_IDLE:   if (in_valid) state_next = rcfg_pkg::S_FOLD;
      rcfg_pkg::S_FOLD: begin
        state_next = status.half_zero ? rcfg_pkg::S_GAIN : rcfg_pkg::S_DIV;
      end
      rcfg_pkg::S_DIV:    if (status.div_last) state_next = rcfg_pkg::S_X;
      rcfg_pkg::S_X:      state_next = rcfg_pkg::S_X2;
      rcfg_pkg::S_X2:     state_next = rcfg_pkg::S_RECIP;
      rcfg_pkg::S_RECIP:  state_next = rcfg_pkg::S_CORR;
      rcfg_pkg::S_CORR: begin
        state_next = status.k_last ? rcfg_pkg::S_SINE : rcfg_pkg::S_TY;
      end
      rcfg_pkg::S_TY:     state_next = rcfg_pkg::S_RECIP;
      rcfg_pkg::S_SINE:   state_next = rcfg_pkg::S_SQ;
      rcfg_pkg::S_SQ:     state_next = rcfg_pkg::S_GAIN;
      rcfg_pkg::S_GAIN:   state_next = rcfg_pkg::S_CMUL;
      rcfg_pkg::S_CMUL:   state_next = rcfg_pkg::S_CSAT;
      rcfg_pkg::S_CSAT: begin
        state_next = status.ch_last ? rcfg_pkg::S_FINISH : rcfg_pkg::S_CMUL;
      end
      rcfg_pkg::S_FINISH: if (!status.out_busy) state_next = rcfg_pkg::S_IDLE;
      default:            state_next = rcfg_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = rcfg_pkg::OP_NONE;
    unique case (state)
      rcfg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = rcfg_pkg::OP_ACCEPT;
      end
      rcfg_pkg::S_FOLD:   cmd.op = rcfg_pkg::OP_FOLD;
      rcfg_pkg::S_DIV:    cmd.op = rcfg_pkg::OP_NONE;
      rcfg_pkg::S_X:      cmd.op = rcfg_pkg::OP_X;
      rcfg_pkg::S_X2:     cmd.op = rcfg_pkg::OP_X2;
      rcfg_pkg::S_RECIP:  cmd.op = rcfg_pkg::OP_RECIP;
      rcfg_pkg::S_CORR:   cmd.op = rcfg_pkg::OP_CORR;
      rcfg_pkg::S_TY:     cmd.op = rcfg_pkg::OP_TY;
      rcfg_pkg::S_SINE:   cmd.op = rcfg_pkg::OP_SINE;
      rcfg_pkg::S_SQ:     cmd.op = rcfg_pkg::OP_SQ;
      rcfg_pkg::S_GAIN:   cmd.op = rcfg_pkg::OP_GAIN;
      rcfg_pkg::S_CMUL:   cmd.op = rcfg_pkg::OP_CMUL;
      rcfg_pkg::S_CSAT:   cmd.op = rcfg_pkg::OP_CSAT;
      rcfg_pkg::S_FINISH: if (!status.out_busy) cmd.op = rcfg_pkg::OP_LOAD;
      default:            cmd.op = rcfg_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- design/rcfg_dp.sv -----
// Datapath of the fade gain core: fade state, phase divider, shared multiplier,
// sine series, per-channel scaling and the output register. Depends on rcfg_pkg and rcfg_div.
module rcfg_dp #(
  parameter int SAMPLE_BITS = rcfg_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNELS    = rcfg_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rcfg_pkg::cfg_wr_t               cfg,
  input  rcfg_pkg::cmd_t                  cmd,
  input  logic [CHANNELS*SAMPLE_BITS-1:0] in_samples,
  input  logic                            start_fade_in,
  input  logic                            start_fade_out,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [CHANNELS*SAMPLE_BITS-1:0] out_samples,
  output logic                            fade_in_done,
  output logic                            fade_out_done,
  output rcfg_pkg::status_t               status
);

  localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_BITS = SAMPLE_BITS + rcfg_pkg::GAIN_BITS;
  localparam int RND_BITS  = PROD_BITS + 1 - rcfg_pkg::GAIN_FRAC;
  localparam int PB        = rcfg_pkg::POS_BITS;
  localparam int LB        = rcfg_pkg::LEN_BITS;
  localparam logic [RND_BITS-1:0] NEG_LIMIT = RND_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [RND_BITS-1:0] POS_LIMIT = NEG_LIMIT - 1'b1;
  localparam logic [PROD_BITS:0]  RND_HALF  =
    (PROD_BITS + 1)'(1) << (rcfg_pkg::GAIN_FRAC - 1);

  // Configuration registers.
  logic [rcfg_pkg::LEVEL_BITS-1:0] level_gain;
  logic [LB-1:0]                   fade_length;

  // Fade state.
  logic [PB-1:0] window_position;
  logic [LB-1:0] half_window;
  logic          in_fade_in;
  logic          in_fade_out;

  // Per-frame work registers.
  logic [PB-1:0]          work_pos;
  logic                   done_in;
  logic                   done_out;
  logic [SAMPLE_BITS-1:0] mag [CHANNELS];
  logic                   neg [CHANNELS];
  logic [SAMPLE_BITS-1:0] res [CHANNELS];
  logic [30:0]            x;
  logic [31:0]            x2;
  logic [31:0]            y;
  logic [31:0]            q;
  logic [30:0]            t;
  logic [31:0]            s;
  logic [16:0]            fgain;
  logic [rcfg_pkg::GAIN_BITS-1:0] gain;
  logic [1:0]             k;
  logic [CH_BITS-1:0]     ch;
  logic [PROD_BITS-1:0]   prodc;

  // Request handling at the input transfer.
  logic [LB-1:0] half_e;
  logic [PB-1:0] pos_e;
  logic          fin_e, fout_e, din_e, dout_e, fin_n, fout_n;
  logic [SAMPLE_BITS-1:0] in_mag [CHANNELS];
  logic                   in_neg [CHANNELS];

  always_comb begin
    half_e = (start_fade_in || start_fade_out) ? fade_length : half_window;
    if (start_fade_out) begin
      pos_e = PB'(fade_length);
    end else if (start_fade_in) begin
      pos_e = '0;
    end else begin
      pos_e = window_position;
    end
    fin_e  = in_fade_in || start_fade_in;
    fout_e = in_fade_out || start_fade_out;
    din_e  = fin_e && (pos_e == PB'(half_e));
    dout_e = fout_e && (pos_e == {half_e, 1'b0});
    fin_n  = fin_e && !din_e;
    fout_n = fout_e && !dout_e;
  end

  // Sign and magnitude of each incoming sample; the most negative code maps to 2^(N-1).
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      in_neg[c] = in_samples[c*SAMPLE_BITS + SAMPLE_BITS - 1];
      in_mag[c] = in_neg[c] ? (~in_samples[c*SAMPLE_BITS +: SAMPLE_BITS] + 1'b1)
                            : in_samples[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // Fold the position into the first half of the window.
  logic [PB-1:0] two_h, p_mod, p_fold;
  always_comb begin
    two_h  = {half_window, 1'b0};
    p_mod  = (work_pos >= two_h) ? (work_pos - two_h) : work_pos;
    p_fold = (p_mod > PB'(half_window)) ? (two_h - p_mod) : p_mod;
  end

  // Phase divider: g = floor(p * 2^30 / half), started by the fold step.
  logic                       div_start;
  logic                       div_last;
  logic [rcfg_pkg::Q_BITS-1:0] g;

  assign div_start = (cmd.op == rcfg_pkg::OP_FOLD) && (half_window != '0);

  rcfg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .divisor   (half_window),
    .rem_init  ({1'b0, p_fold[LB-1:1]}),
    .bits_init ({p_fold[0], {(rcfg_pkg::Q_BITS-1){1'b0}}}),
    .last      (div_last),
    .quotient  (g)
  );

  // Shared 32x32 multiplier; the controller picks the operands.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      rcfg_pkg::OP_X: begin
        mul_a = 32'(g);
        mul_b = 32'(rcfg_pkg::HALF_PI_Q30);
      end
      rcfg_pkg::OP_X2: begin
        mul_a = 32'(x);
        mul_b = 32'(x);
      end
      rcfg_pkg::OP_RECIP: begin
        mul_a = y;
        mul_b = rcfg_pkg::series_recip(k);
      end
      rcfg_pkg::OP_TY: begin
        mul_a = x2;
        mul_b = 32'(t);
      end
      rcfg_pkg::OP_SINE: begin
        mul_a = 32'(x);
        mul_b = 32'(t);
      end
      rcfg_pkg::OP_SQ: begin
        mul_a = s;
        mul_b = s;
      end
      rcfg_pkg::OP_GAIN: begin
        mul_a = 32'(fgain);
        mul_b = 32'(level_gain);
      end
      rcfg_pkg::OP_CMUL: begin
        mul_a = 32'(mag[ch]);
        mul_b = 32'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Reciprocal quotient correction: the estimate is low by at most one.
  logic [6:0]  sdiv;
  logic [38:0] qc;
  logic [31:0] qrem;
  logic [31:0] qt;

  always_comb begin
    sdiv = rcfg_pkg::series_div(k);
    qc   = 39'(q) * 39'(sdiv);
    qrem = y - qc[31:0];
    qt   = q + 32'(qrem >= 32'(sdiv));
  end

  // Fade gain rounding and clamp, combined gain rounding.
  logic [63:0] sq;
  logic [19:0] fq;
  logic [36:0] gsum;

  always_comb begin
    sq   = mul_p + (64'd1 << 43);
    fq   = sq[63:44];
    gsum = mul_p[36:0] + 37'd128;
  end

  // Rounding and saturation of the current channel.
  logic [PROD_BITS:0]  rsum;
  logic [RND_BITS-1:0] rnd, sat_mag, sat_neg;

  always_comb begin
    rsum    = {1'b0, prodc} + RND_HALF;
    rnd     = rsum[PROD_BITS:rcfg_pkg::GAIN_FRAC];
    if (neg[ch]) begin
      sat_mag = (rnd > NEG_LIMIT) ? NEG_LIMIT : rnd;
    end else begin
      sat_mag = (rnd > POS_LIMIT) ? POS_LIMIT : rnd;
    end
    sat_neg = ~sat_mag + 1'b1;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_gain  <= rcfg_pkg::LEVEL_GAIN_RESET;
      fade_length <= '0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        rcfg_pkg::REG_LEVEL_GAIN:  level_gain  <= cfg.data;
        rcfg_pkg::REG_FADE_LENGTH: fade_length <= LB'(cfg.data);
        default: ;
      endcase
    end
  end

  // Fade state: requests, done checks and position advance all settle at the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_position <= '0;
      half_window     <= '0;
      in_fade_in      <= 1'b0;
      in_fade_out     <= 1'b0;
    end else if (cmd.op == rcfg_pkg::OP_ACCEPT) begin
      half_window     <= half_e;
      in_fade_in      <= fin_n;
      in_fade_out     <= fout_n;
      window_position <= (fin_n || fout_n) ? (pos_e + 1'b1) : pos_e;
    end
  end

  // Work registers of the gain computation.
  always_ff @(posedge clk) begin
    case (cmd.op)
      rcfg_pkg::OP_ACCEPT: begin
        work_pos <= pos_e;
        done_in  <= din_e;
        done_out <= dout_e;
        for (int c = 0; c < CHANNELS; c++) begin
          mag[c] <= in_mag[c];
          neg[c] <= in_neg[c];
        end
      end
      rcfg_pkg::OP_FOLD: begin
        fgain <= rcfg_pkg::FADE_UNITY;
      end
      rcfg_pkg::OP_X: begin
        x <= mul_p[60:30];
      end
      rcfg_pkg::OP_X2: begin
        x2 <= mul_p[61:30];
        y  <= mul_p[61:30];
        k  <= '0;
      end
      rcfg_pkg::OP_RECIP: begin
        q <= mul_p[63:32];
      end
      rcfg_pkg::OP_CORR: begin
        t <= rcfg_pkg::Q30_ONE - qt[30:0];
        k <= k + 1'b1;
      end
      rcfg_pkg::OP_TY: begin
        y <= mul_p[61:30];
      end
      rcfg_pkg::OP_SINE: begin
        s <= mul_p[61:30];
      end
      rcfg_pkg::OP_SQ: begin
        fgain <= (fq > 20'(rcfg_pkg::FADE_UNITY)) ? rcfg_pkg::FADE_UNITY : fq[16:0];
      end
      rcfg_pkg::OP_GAIN: begin
        gain <= gsum[36:8];
        ch   <= '0;
      end
      rcfg_pkg::OP_CMUL: begin
        prodc <= mul_p[PROD_BITS-1:0];
      end
      rcfg_pkg::OP_CSAT: begin
        res[ch] <= neg[ch] ? SAMPLE_BITS'(sat_neg) : SAMPLE_BITS'(sat_mag);
        ch      <= ch + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: a finished frame waits here while the next one is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == rcfg_pkg::OP_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rcfg_pkg::OP_LOAD) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_samples[c*SAMPLE_BITS +: SAMPLE_BITS] <= res[c];
      end
      fade_in_done  <= done_in;
      fade_out_done <= done_out;
    end
  end

  // Status to the controller.
  assign status.half_zero = (half_window == '0);
  assign status.div_last  = div_last;
  assign status.k_last    = (k == 2'(rcfg_pkg::SERIES_TERMS - 1));
  assign status.ch_last   = (ch == CH_BITS'(CHANNELS - 1));
  assign status.out_busy  = out_valid && !out_ready;

endmodule

// ----- design/raised_cosine_fade_gain_core.sv -----
// Top level of the raised cosine fade gain core.
// Depends on rcfg_pkg, rcfg_ctrl, rcfg_dp, rcfg_div and raised_cosine_fade_gain_core_defines.svh.
//
// Scales each multichannel frame by level_gain times sin^2(pi*pos/(2*half)) and flags
// the end of fade-in and fade-out windows; results are rounded half away from zero and
// saturated. One frame is worked at a time: while the half length is nonzero a frame
// passes through the bit-per-cycle phase divider and then through steps of the single
// shared 32x32 multiplier that runs the sine series and scales one channel after the
// other; the divider and series are skipped while the half length is zero. A finished
// frame waits in the output register, so the next input transfer is taken while the
// result is still pending; the core only waits when a second result is ready before
// the first is taken.
// Configuration writes are taken in any cycle and must only be made while the core is idle.
`include "raised_cosine_fade_gain_core_defines.svh"

module raised_cosine_fade_gain_core #(
  parameter int SAMPLE_BITS = rcfg_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNELS    = rcfg_pkg::CHANNELS_DEF,
  localparam int TDATA_BITS = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcfg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rcfg_pkg::LEVEL_BITS-1:0]       cfg_data,
  // Input frames.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [TDATA_BITS-1:0]                 s_axis_tdata,  // left_sample, right_sample, ...
  input  logic [1:0]                            s_axis_tuser,  // start_fade_in, start_fade_out
  // Result frames.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [TDATA_BITS-1:0]                 m_axis_tdata,  // left_out, right_out, ...
  output logic [1:0]                            m_axis_tuser   // fade_in_done, fade_out_done
);

  rcfg_pkg::cmd_t                  cmd;
  rcfg_pkg::status_t               status;
  rcfg_pkg::cfg_wr_t               cfg;
  logic [CHANNELS*SAMPLE_BITS-1:0] out_samples;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rcfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  rcfg_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .in_samples     (s_axis_tdata[CHANNELS*SAMPLE_BITS-1:0]),
    .start_fade_in  (s_axis_tuser[0]),
    .start_fade_out (s_axis_tuser[1]),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .out_samples    (out_samples),
    .fade_in_done   (m_axis_tuser[0]),
    .fade_out_done  (m_axis_tuser[1]),
    .status         (status)
  );

  // Pad the packed samples with zeros up to whole bytes.
  assign m_axis_tdata = TDATA_BITS'(out_samples);

  // A frame is only taken in while the input side shows ready.
  `RCFG_ASSERT_HOLDS(a_accept_needs_transfer, cmd.op == rcfg_pkg::OP_ACCEPT, s_axis_tvalid && s_axis_tready, "frame taken without an input transfer")
  // A new result never overwrites one that is still waiting.
  `RCFG_ASSERT_HOLDS(a_load_no_overwrite, cmd.op == rcfg_pkg::OP_LOAD, !m_axis_tvalid || m_axis_tready, "pending result overwritten")
  // A loaded result is offered in the next cycle.
  `RCFG_ASSERT_NEXT(a_load_shows_result, cmd.op == rcfg_pkg::OP_LOAD, m_axis_tvalid, "loaded result not offered")
  // The phase divider only finishes while a frame is in work.
  `RCFG_ASSERT_HOLDS(a_div_in_work, status.div_last, !s_axis_tready, "divider finished while idle")

endmodule
